### rtl/core/clr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_pkg
// Shared types and constants for the clamped line rasteriser.
// ----------------------------------------------------------------------------
package clr_pkg;

	localparam int COORD_W     = 6;
	localparam int SIZE_W      = 7;
	localparam int ERR_W       = 10;
	localparam int ADDR_W      = 12;
	localparam int GLYPH_W     = 8;
	localparam int IN_W        = 16;
	localparam int SIZE_CAP    = 64;

	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	// register index, taken from paddr[2]
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_WALK
	} clr_state_t;

	typedef struct packed {
		logic capture;
		logic setup;
		logic step;
	} clr_cmd_t;

	typedef struct packed {
		logic zero_len;
		logic last;
		logic out_free;
	} clr_sts_t;

endpackage

### rtl/core/clamped_line_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clamped_line_rasterizer
// Clamps two endpoints into the buffer and walks the line with Bresenham
// error stepping, one pixel write per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one line command: start_x/y,
//   end_x/y (signed 16 bit) and a glyph. Output channel (out_valid/out_stall)
//   gives one transfer per plotted point: point_x/y, cell_address, glyph_out,
//   with last_point set on the final one. The far endpoint is not plotted;
//   a line whose clamped endpoints coincide gives no transfer.
//   The command is captured in idle, the walker is loaded in set-up, and each
//   step then loads a point into the output register; the Bresenham stepper
//   gives one point per cycle while the output is free, at most 63 points.
//   The next command is taken while the last point still waits in the
//   output register.
//   out_stall holds the output register and freezes the stepper.
//   Width and height registers sit at byte addresses 0 and 4 of the APB port;
//   write them only while idle. Reset sets both to 64 and empties the output.
// ----------------------------------------------------------------------------
module clamped_line_rasterizer
	import clr_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [IN_W-1:0] start_x,
	input  logic signed [IN_W-1:0] start_y,
	input  logic signed [IN_W-1:0] end_x,
	input  logic signed [IN_W-1:0] end_y,
	input  logic [GLYPH_W-1:0]     glyph,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [COORD_W-1:0]     point_x,
	output logic [COORD_W-1:0]     point_y,
	output logic [ADDR_W-1:0]      cell_address,
	output logic [GLYPH_W-1:0]     glyph_out,
	output logic                   last_point
);

	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
				REG_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				default:    width_q  <= width_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = {(32-SIZE_W)'(0), width_q};
			REG_HEIGHT: prdata = {(32-SIZE_W)'(0), height_q};
			default:    prdata = '0;
		endcase
	end

	clr_cmd_t cmd;
	clr_sts_t sts;

	clr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	clr_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.width_cfg    (width_q),
		.height_cfg   (height_q),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.glyph        (glyph),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.point_x      (point_x),
		.point_y      (point_y),
		.cell_address (cell_address),
		.glyph_out    (glyph_out),
		.last_point   (last_point)
	);

endmodule

### rtl/core/clr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_ctrl
// Command sequencer: accept, set up, then walk one point per transfer.
// ----------------------------------------------------------------------------
module clr_ctrl
	import clr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  clr_sts_t sts,
	output clr_cmd_t cmd
);

	clr_state_t state_q;
	clr_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				state_d = sts.zero_len ? ST_IDLE : ST_WALK;
			end
			ST_WALK: begin
				if (sts.out_free && sts.last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
			end
			ST_WALK: begin
				cmd.step = sts.out_free;
			end
			default: in_stall = 1'b1;
		endcase
	end

endmodule

### rtl/core/clr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_datapath
// Endpoint clamping, line classification, Bresenham stepper and output
// register.
// ----------------------------------------------------------------------------
module clr_datapath
	import clr_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  clr_cmd_t                  cmd,
	output clr_sts_t                  sts,
	input  logic [SIZE_W-1:0]         width_cfg,
	input  logic [SIZE_W-1:0]         height_cfg,
	input  logic signed [IN_W-1:0]    start_x,
	input  logic signed [IN_W-1:0]    start_y,
	input  logic signed [IN_W-1:0]    end_x,
	input  logic signed [IN_W-1:0]    end_y,
	input  logic [GLYPH_W-1:0]        glyph,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [COORD_W-1:0]        point_x,
	output logic [COORD_W-1:0]        point_y,
	output logic [ADDR_W-1:0]         cell_address,
	output logic [GLYPH_W-1:0]        glyph_out,
	output logic                      last_point
);

	localparam int W_CAP = (MAX_WIDTH < SIZE_CAP) ? MAX_WIDTH : SIZE_CAP;
	localparam int H_CAP = (MAX_HEIGHT < SIZE_CAP) ? MAX_HEIGHT : SIZE_CAP;

	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
			input logic [SIZE_W-1:0] cap);
		logic [SIZE_W-1:0] s;
		s = (r == '0) ? SIZE_W'(1) : r;
		if (s > cap) s = cap;
		return s;
	endfunction

	function automatic logic [COORD_W-1:0] clamp(input logic signed [IN_W-1:0] v,
			input logic [COORD_W-1:0] hi);
		logic [COORD_W-1:0] r;
		if (v[IN_W-1]) r = '0;
		else if (v > $signed({(IN_W-COORD_W)'(0), hi})) r = hi;
		else r = v[COORD_W-1:0];
		return r;
	endfunction

	logic [SIZE_W-1:0]  w_eff;
	logic [SIZE_W-1:0]  h_eff;
	logic [COORD_W-1:0] x_hi;
	logic [COORD_W-1:0] y_hi;

	assign w_eff = eff_size(width_cfg, SIZE_W'(W_CAP));
	assign h_eff = eff_size(height_cfg, SIZE_W'(H_CAP));
	assign x_hi  = COORD_W'(w_eff - SIZE_W'(1));
	assign y_hi  = COORD_W'(h_eff - SIZE_W'(1));

	// clamped endpoints
	logic [COORD_W-1:0] x0_q, y0_q, x1_q, y1_q;
	logic [GLYPH_W-1:0] glyph_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x0_q    <= clamp(start_x, x_hi);
			y0_q    <= clamp(start_y, y_hi);
			x1_q    <= clamp(end_x, x_hi);
			y1_q    <= clamp(end_y, y_hi);
			glyph_q <= glyph;
		end
	end

	// classification
	logic [COORD_W-1:0] adx, ady;
	logic               steep;
	logic               swap;
	logic [COORD_W-1:0] sx, sy, ex, ey;
	logic [COORD_W-1:0] maj0, min0, stop0, dmaj0, dmin0;
	logic               neg0;
	logic signed [ERR_W-1:0] err0;

	always_comb begin
		adx   = (x1_q >= x0_q) ? x1_q - x0_q : x0_q - x1_q;
		ady   = (y1_q >= y0_q) ? y1_q - y0_q : y0_q - y1_q;
		steep = (ady >= adx);
		swap  = steep ? (y0_q > y1_q) : (x0_q > x1_q);
		sx    = swap ? x1_q : x0_q;
		sy    = swap ? y1_q : y0_q;
		ex    = swap ? x0_q : x1_q;
		ey    = swap ? y0_q : y1_q;
		if (steep) begin
			maj0  = sy;
			min0  = sx;
			stop0 = ey;
			dmaj0 = ady;
			dmin0 = adx;
			neg0  = (ex < sx);
		end else begin
			maj0  = sx;
			min0  = sy;
			stop0 = ex;
			dmaj0 = adx;
			dmin0 = ady;
			neg0  = (ey < sy);
		end
		err0 = $signed({(ERR_W-COORD_W-1)'(0), dmin0, 1'b0})
			- $signed({(ERR_W-COORD_W)'(0), dmaj0});
	end

	// walker state
	logic                    steep_q;
	logic [COORD_W-1:0]      cur_major_q;
	logic [COORD_W-1:0]      cur_minor_q;
	logic [COORD_W-1:0]      stop_q;
	logic [COORD_W-1:0]      dmaj_q;
	logic [COORD_W-1:0]      dmin_q;
	logic                    neg_q;
	logic signed [ERR_W-1:0] err_q;

	logic signed [ERR_W-1:0] two_dmin;
	logic signed [ERR_W-1:0] two_diff;
	logic [COORD_W:0]        major_inc;
	logic [COORD_W-1:0]      px, py;

	assign two_dmin  = $signed({(ERR_W-COORD_W-1)'(0), dmin_q, 1'b0});
	assign two_diff  = two_dmin - $signed({(ERR_W-COORD_W-1)'(0), dmaj_q, 1'b0});
	assign major_inc = {1'b0, cur_major_q} + (COORD_W+1)'(1);
	assign px        = steep_q ? cur_minor_q : cur_major_q;
	assign py        = steep_q ? cur_major_q : cur_minor_q;

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			steep_q     <= steep;
			cur_major_q <= maj0;
			cur_minor_q <= min0;
			stop_q      <= stop0;
			dmaj_q      <= dmaj0;
			dmin_q      <= dmin0;
			neg_q       <= neg0;
			err_q       <= err0;
		end else if (cmd.step) begin
			cur_major_q <= major_inc[COORD_W-1:0];
			if (err_q > 0) begin
				cur_minor_q <= neg_q ? cur_minor_q - COORD_W'(1)
					: cur_minor_q + COORD_W'(1);
				err_q       <= err_q + two_diff;
			end else begin
				err_q <= err_q + two_dmin;
			end
		end
	end

	// output register
	logic                 out_valid_q;
	logic [COORD_W-1:0]   point_x_q, point_y_q;
	logic [ADDR_W-1:0]    cell_address_q;
	logic [GLYPH_W-1:0]   glyph_out_q;
	logic                 last_point_q;
	logic [SIZE_W+COORD_W-1:0] row_base;

	assign row_base = w_eff * py;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			point_x_q      <= px;
			point_y_q      <= py;
			cell_address_q <= ADDR_W'(row_base + (SIZE_W+COORD_W)'(px));
			glyph_out_q    <= glyph_q;
			last_point_q   <= sts.last;
		end
	end

	assign sts.zero_len = (dmaj0 == '0);
	assign sts.last     = (major_inc == {1'b0, stop_q});
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign point_x      = point_x_q;
	assign point_y      = point_y_q;
	assign cell_address = cell_address_q;
	assign glyph_out    = glyph_out_q;
	assign last_point   = last_point_q;

`ifndef SYNTHESIS
	a_step_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> sts.out_free)
		else $error("step issued while output register busy");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (cur_major_q < stop_q))
		else $error("walker stepped past its stop coordinate");

	a_zero_len_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.setup && sts.zero_len |=> !cmd.step)
		else $error("degenerate line produced a point");
`endif

endmodule
